>>> rtl/core/bms_pkg.sv
// ============================================================================
// bms_pkg
// Shared widths, limits, reset values and codes of the tiled mean and
// standard deviation block.
// ============================================================================
`default_nettype none

package bms_pkg;

    // Limits of the tile grid and the frame.
    localparam int MAX_X_BLOCKS = 16;
    localparam int MAX_Y_BLOCKS = 64;
    localparam int MAX_DIM      = 4096;

    // Field and register widths.
    localparam int PIX_W   = 8;
    localparam int DIM_W   = 13;
    localparam int XB_W    = 5;
    localparam int YB_W    = 7;
    localparam int POS_W   = 12;
    localparam int BAND_W  = 6;
    localparam int COL_W   = 4;
    localparam int Q_W     = 16;
    localparam int STAT_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int ADDR_W  = $clog2(MAX_X_BLOCKS);

    // Accumulator widths and the entry of the accumulator memory.
    localparam int SUM_W   = 32;
    localparam int SQ_W    = 40;
    localparam int ENTRY_W = SUM_W + SQ_W;

    // Tile size product and the shared divider.
    localparam int N_W      = 25;
    localparam int DVD_W    = 41;
    localparam int DSH_W    = DVD_W - 1;

    // Square root unit.
    localparam int RAD_W    = 82;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int VAR_W    = 66;

    // Output item.
    localparam int OUT_W    = 48;

    // Reset values of the configuration and what follows from them.
    localparam logic [DIM_W-1:0] RST_ROW_WIDTH    = 13'd640;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [XB_W-1:0]  RST_X_BLOCKS     = 5'd4;
    localparam logic [YB_W-1:0]  RST_Y_BLOCKS     = 7'd4;
    localparam int RST_SUBW = 640 / 4;
    localparam int RST_SUBH = 480 / 4;
    localparam logic [DIM_W-1:0] RST_SUB_W   = DIM_W'(RST_SUBW);
    localparam logic [DIM_W-1:0] RST_SUB_H   = DIM_W'(RST_SUBH);
    localparam logic [N_W-1:0]   RST_N       = N_W'(RST_SUBW * RST_SUBH);

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SIZE   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BLOCKS = 2'd2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_ROW_WIDTH    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] REG_X_BLOCKS     = 2'd2;
    localparam logic [CIDX_W-1:0] REG_Y_BLOCKS     = 2'd3;

endpackage

`default_nettype wire

>>> rtl/core/block_mean_stddev.sv
// ============================================================================
// block_mean_stddev
// Tiled mean and standard deviation of a gray pixel stream.
// ============================================================================
// Pixels enter on the s_ channel in raster order; s_tuser marks the first
// pixel of a frame. Results leave on the m_ channel, one item per tile, left
// to right, after the last pixel of each tile band; m_tlast flags the final
// item caused by a pixel. With an invalid configuration every pixel gives
// one error item. Registers are written on the cfg_ channel.
// A pixel reads its tile accumulator from the memory when it is accepted
// and writes it back from the ST_ACC state. A pixel that ends a band then
// runs each tile through the 16-step divider (twice) and the 41-step square
// root unit. After its acceptance, a configuration write derives the tile
// size through the same divider; no pixel is taken meanwhile. An error item
// is placed once the output slot is free.
// The output register holds one item; while the receiver stalls, the block
// keeps accepting pixels and stops only when it has a new item to place.
// Reset restores the default 640x480 frame in a 4x4 grid and clears the
// positions and all tile accumulators at once.
// ============================================================================
`default_nettype none

module block_mean_stddev (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Pixel input.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [bms_pkg::PIX_W-1:0]         s_tdata,   // pixel
    input  wire logic                              s_tuser,   // start_frame
    // Result output.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tile_column[3:0], tile_row[9:4], mean_q8[25:10], stddev_q8[41:26],
    // status[43:42], zero fill[47:44]
    output logic      [bms_pkg::OUT_W-1:0]         m_tdata,
    output logic                                   m_tlast,   // last
    // Configuration writes.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bms_pkg::CIDX_W-1:0]        cfg_index,
    input  wire logic [bms_pkg::DIM_W-1:0]         cfg_data
);

    typedef enum logic [17:0] {
        ST_IDLE   = 18'h00001,
        ST_CDIV_W = 18'h00002,
        ST_CDIV_H = 18'h00004,
        ST_CDIV_C = 18'h00008,
        ST_CMUL   = 18'h00010,
        ST_CN     = 18'h00020,
        ST_ACC    = 18'h00040,
        ST_ERR    = 18'h00080,
        ST_TRD    = 18'h00100,
        ST_TLD    = 18'h00200,
        ST_M0     = 18'h00400,
        ST_M1     = 18'h00800,
        ST_M2     = 18'h01000,
        ST_VAR    = 18'h02000,
        ST_MDIV   = 18'h04000,
        ST_SQRT   = 18'h08000,
        ST_SDIV   = 18'h10000,
        ST_EMIT   = 18'h20000
    } state_t;

    localparam int PW = bms_pkg::POS_W;
    localparam int DW = bms_pkg::DIM_W;

    state_t state_reg, state_next;

    // Configuration and derived tile geometry.
    logic [DW-1:0]                 rw_reg, rw_next;
    logic [DW-1:0]                 fh_reg, fh_next;
    logic [bms_pkg::XB_W-1:0]      xb_reg, xb_next;
    logic [bms_pkg::YB_W-1:0]      yb_reg, yb_next;
    logic [DW-1:0]                 subw_reg, subw_next;
    logic [DW-1:0]                 subh_reg, subh_next;
    logic [bms_pkg::N_W-1:0]       n_reg, n_next;
    logic [bms_pkg::STAT_W-1:0]    status_reg, status_next;
    logic                          remw_nz_reg, remw_nz_next;

    // Position state.
    logic [PW-1:0]                 col_reg, col_next;
    logic [PW-1:0]                 row_reg, row_next;
    logic [PW-1:0]                 tx_reg, tx_next;
    logic [PW-1:0]                 cit_reg, cit_next;
    logic [bms_pkg::BAND_W-1:0]    band_reg, band_next;
    logic [bms_pkg::MAX_X_BLOCKS-1:0] valid_reg, valid_next;

    // Per-pixel and per-tile working registers.
    logic [bms_pkg::PIX_W-1:0]     pix_reg, pix_next;
    logic [bms_pkg::ADDR_W-1:0]    addr_reg, addr_next;
    logic                          bend_reg, bend_next;
    logic [bms_pkg::COL_W-1:0]     k_reg, k_next;
    logic [bms_pkg::SUM_W-1:0]     s1_reg, s1_next;
    logic [bms_pkg::SQ_W-1:0]      s2_reg, s2_next;
    logic [63:0]                   prod_reg;
    logic [bms_pkg::VAR_W-1:0]     acc_reg, acc_next;
    logic [bms_pkg::VAR_W-1:0]     var_reg, var_next;
    logic [bms_pkg::Q_W-1:0]       mean_reg, mean_next;
    logic [bms_pkg::ROOT_W-1:0]    root_reg, root_next;
    logic [bms_pkg::Q_W-1:0]       sd_reg, sd_next;
    logic                          div_go_reg, div_go_next;
    logic                          sq_go_reg, sq_go_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic [bms_pkg::OUT_W-1:0]     out_data_reg, out_data_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_free;

    // Multiplier, memory, divider and square root connections.
    logic [31:0]                   mul_a, mul_b;
    logic                          ram_we;
    logic [bms_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [bms_pkg::ADDR_W-1:0]    ram_raddr;
    logic [bms_pkg::ENTRY_W-1:0]   ram_rdata;
    logic [bms_pkg::SUM_W-1:0]     rd_sum;
    logic [bms_pkg::SQ_W-1:0]      rd_sq;
    logic                          rd_valid;
    logic [bms_pkg::DVD_W-1:0]     div_dividend;
    logic [bms_pkg::N_W-1:0]       div_divisor;
    logic                          div_done;
    logic [bms_pkg::Q_W-1:0]       div_quot;
    logic [bms_pkg::N_W-1:0]       div_rem;
    logic                          sq_done;
    logic [bms_pkg::ROOT_W-1:0]    sq_root;

    // Pixel step helpers.
    logic                          s_acc;
    logic                          cfg_acc;
    logic [PW-1:0]                 col_eff, row_eff, tx_eff, cit_eff;
    logic [DW-1:0]                 col1, row1, cit1;
    logic                          acc_en;
    logic                          st2_bad;
    logic                          st1_bad;
    logic                          tile_last;
    logic [bms_pkg::YB_W-1:0]      band1;

    bms_acc_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    bms_isqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_go_reg),
        .radicand ({var_reg, 16'b0}),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Handshakes.
    assign cfg_ready = state_reg == ST_IDLE;
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // Memory read data, with entries not written since clearing read as zero.
    assign rd_valid = valid_reg[addr_reg];
    assign rd_sum   = rd_valid ? ram_rdata[bms_pkg::SUM_W-1:0] : '0;
    assign rd_sq    = rd_valid ? ram_rdata[bms_pkg::ENTRY_W-1:bms_pkg::SUM_W] : '0;
    assign ram_we   = state_reg == ST_ACC;
    assign ram_wdata = {rd_sq + bms_pkg::SQ_W'(pix_reg * pix_reg),
                        rd_sum + bms_pkg::SUM_W'(pix_reg)};

    // Position of this pixel after an optional frame start.
    assign col_eff  = s_tuser ? '0 : col_reg;
    assign row_eff  = s_tuser ? '0 : row_reg;
    assign tx_eff   = s_tuser ? '0 : tx_reg;
    assign cit_eff  = s_tuser ? '0 : cit_reg;
    assign col1     = {1'b0, col_eff} + 13'd1;
    assign row1     = {1'b0, row_eff} + 13'd1;
    assign cit1     = {1'b0, cit_eff} + 13'd1;
    assign acc_en   = tx_eff < {7'b0, xb_reg};

    // Configuration checks.
    assign st2_bad = (xb_reg == '0) || (yb_reg == '0)
                   || (xb_reg > 5'(bms_pkg::MAX_X_BLOCKS))
                   || (yb_reg > 7'(bms_pkg::MAX_Y_BLOCKS));
    assign st1_bad = (rw_reg == '0) || (fh_reg == '0)
                   || (rw_reg > 13'(bms_pkg::MAX_DIM))
                   || (fh_reg > 13'(bms_pkg::MAX_DIM))
                   || remw_nz_reg || (div_rem != '0);

    assign tile_last = ({1'b0, k_reg} + 5'd1) == xb_reg;
    assign band1     = {1'b0, band_reg} + 7'd1;

    // Memory read address.
    always_comb
    begin
        if (state_reg == ST_TRD)
        begin
            ram_raddr = k_reg;
        end
        else
        begin
            ram_raddr = tx_eff[bms_pkg::ADDR_W-1:0];
        end
    end

    // Shared multiplier operands.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_CMUL:
            begin
                mul_a = {19'b0, subw_reg};
                mul_b = {19'b0, subh_reg};
            end
            ST_M0:
            begin
                mul_a = {7'b0, n_reg};
                mul_b = {12'b0, s2_reg[19:0]};
            end
            ST_M1:
            begin
                mul_a = {7'b0, n_reg};
                mul_b = {12'b0, s2_reg[39:20]};
            end
            ST_M2:
            begin
                mul_a = s1_reg;
                mul_b = s1_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared divider operands.
    always_comb
    begin
        unique case (state_reg)
            ST_CDIV_W:
            begin
                div_dividend = {28'b0, rw_reg};
                div_divisor  = {20'b0, xb_reg};
            end
            ST_CDIV_H:
            begin
                div_dividend = {28'b0, fh_reg};
                div_divisor  = {18'b0, yb_reg};
            end
            ST_CDIV_C:
            begin
                div_dividend = {29'b0, col_reg};
                div_divisor  = {12'b0, subw_reg};
            end
            ST_SDIV:
            begin
                div_dividend = root_reg;
                div_divisor  = n_reg;
            end
            default:
            begin
                div_dividend = {1'b0, s1_reg, 8'b0};
                div_divisor  = n_reg;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        rw_next        = rw_reg;
        fh_next        = fh_reg;
        xb_next        = xb_reg;
        yb_next        = yb_reg;
        subw_next      = subw_reg;
        subh_next      = subh_reg;
        n_next         = n_reg;
        status_next    = status_reg;
        remw_nz_next   = remw_nz_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        tx_next        = tx_reg;
        cit_next       = cit_reg;
        band_next      = band_reg;
        valid_next     = valid_reg;
        pix_next       = pix_reg;
        addr_next      = addr_reg;
        bend_next      = bend_reg;
        k_next         = k_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        acc_next       = acc_reg;
        var_next       = var_reg;
        mean_next      = mean_reg;
        root_next      = root_reg;
        sd_next        = sd_reg;
        div_go_next    = 1'b0;
        sq_go_next     = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_acc)
                begin
                    unique case (cfg_index)
                        bms_pkg::REG_ROW_WIDTH:    rw_next = cfg_data;
                        bms_pkg::REG_FRAME_HEIGHT: fh_next = cfg_data;
                        bms_pkg::REG_X_BLOCKS:     xb_next = cfg_data[bms_pkg::XB_W-1:0];
                        bms_pkg::REG_Y_BLOCKS:     yb_next = cfg_data[bms_pkg::YB_W-1:0];
                        default:                   rw_next = rw_reg;
                    endcase
                    state_next  = ST_CDIV_W;
                    div_go_next = 1'b1;
                end
                else if (s_acc)
                begin
                    if (s_tuser)
                    begin
                        valid_next = '0;
                        col_next   = '0;
                        row_next   = '0;
                        tx_next    = '0;
                        cit_next   = '0;
                        band_next  = '0;
                    end
                    if (status_reg != bms_pkg::STAT_OK)
                    begin
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        pix_next  = s_tdata;
                        addr_next = tx_eff[bms_pkg::ADDR_W-1:0];
                        bend_next = 1'b0;
                        k_next    = '0;
                        if (col1 < rw_reg)
                        begin
                            col_next = col1[PW-1:0];
                            if (cit1 == subw_reg)
                            begin
                                cit_next = '0;
                                tx_next  = tx_eff + 12'd1;
                            end
                            else
                            begin
                                cit_next = cit1[PW-1:0];
                                tx_next  = tx_eff;
                            end
                        end
                        else
                        begin
                            col_next = '0;
                            cit_next = '0;
                            tx_next  = '0;
                            if (row1 < subh_reg)
                            begin
                                row_next = row1[PW-1:0];
                            end
                            else
                            begin
                                row_next  = '0;
                                bend_next = 1'b1;
                            end
                        end
                        if (acc_en)
                        begin
                            state_next = ST_ACC;
                        end
                        else if (!(col1 < rw_reg) && !(row1 < subh_reg))
                        begin
                            state_next = ST_TRD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            // Derive the tile width, then the height, then the column tile.
            ST_CDIV_W:
            begin
                if (st2_bad)
                begin
                    status_next = bms_pkg::STAT_BLOCKS;
                    state_next  = ST_IDLE;
                end
                else if (div_done && !div_go_reg)
                begin
                    subw_next    = div_quot[DW-1:0];
                    remw_nz_next = div_rem != '0;
                    state_next   = ST_CDIV_H;
                    div_go_next  = 1'b1;
                end
            end

            ST_CDIV_H:
            begin
                if (div_done && !div_go_reg)
                begin
                    subh_next = div_quot[DW-1:0];
                    if (st1_bad)
                    begin
                        status_next = bms_pkg::STAT_SIZE;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next  = ST_CDIV_C;
                        div_go_next = 1'b1;
                    end
                end
            end

            ST_CDIV_C:
            begin
                if (div_done && !div_go_reg)
                begin
                    tx_next    = div_quot[PW-1:0];
                    cit_next   = div_rem[PW-1:0];
                    state_next = ST_CMUL;
                end
            end

            ST_CMUL:
            begin
                state_next = ST_CN;
            end

            ST_CN:
            begin
                n_next      = prod_reg[bms_pkg::N_W-1:0];
                status_next = bms_pkg::STAT_OK;
                state_next  = ST_IDLE;
            end

            // Read-modify-write of the pixel's tile accumulator.
            ST_ACC:
            begin
                valid_next[addr_reg] = 1'b1;
                state_next = bend_reg ? ST_TRD : ST_IDLE;
            end

            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0, status_reg, 42'b0};
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            // Tile results of a finished band.
            ST_TRD:
            begin
                addr_next  = k_reg;
                state_next = ST_TLD;
            end

            ST_TLD:
            begin
                s1_next              = rd_sum;
                s2_next              = rd_sq;
                valid_next[addr_reg] = 1'b0;
                state_next           = ST_M0;
            end

            ST_M0:
            begin
                state_next = ST_M1;
            end

            ST_M1:
            begin
                acc_next   = {2'b0, prod_reg};
                state_next = ST_M2;
            end

            ST_M2:
            begin
                acc_next   = acc_reg + {prod_reg[45:0], 20'b0};
                state_next = ST_VAR;
            end

            ST_VAR:
            begin
                if (acc_reg >= {2'b0, prod_reg})
                begin
                    var_next = acc_reg - {2'b0, prod_reg};
                end
                else
                begin
                    var_next = '0;
                end
                state_next  = ST_MDIV;
                div_go_next = 1'b1;
            end

            ST_MDIV:
            begin
                if (div_done && !div_go_reg)
                begin
                    mean_next  = div_quot;
                    state_next = ST_SQRT;
                    sq_go_next = 1'b1;
                end
            end

            ST_SQRT:
            begin
                if (sq_done && !sq_go_reg)
                begin
                    root_next   = sq_root;
                    state_next  = ST_SDIV;
                    div_go_next = 1'b1;
                end
            end

            ST_SDIV:
            begin
                if (div_done && !div_go_reg)
                begin
                    sd_next    = div_quot;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0, bms_pkg::STAT_OK, sd_reg, mean_reg,
                                      band_reg, k_reg};
                    out_last_next  = tile_last;
                    if (tile_last)
                    begin
                        band_next  = (band1 >= yb_reg) ? '0 : band1[bms_pkg::BAND_W-1:0];
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 4'd1;
                        state_next = ST_TRD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rw_reg        <= bms_pkg::RST_ROW_WIDTH;
            fh_reg        <= bms_pkg::RST_FRAME_HEIGHT;
            xb_reg        <= bms_pkg::RST_X_BLOCKS;
            yb_reg        <= bms_pkg::RST_Y_BLOCKS;
            subw_reg      <= bms_pkg::RST_SUB_W;
            subh_reg      <= bms_pkg::RST_SUB_H;
            n_reg         <= bms_pkg::RST_N;
            status_reg    <= bms_pkg::STAT_OK;
            remw_nz_reg   <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            tx_reg        <= '0;
            cit_reg       <= '0;
            band_reg      <= '0;
            valid_reg     <= '0;
            bend_reg      <= 1'b0;
            k_reg         <= '0;
            div_go_reg    <= 1'b0;
            sq_go_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rw_reg        <= rw_next;
            fh_reg        <= fh_next;
            xb_reg        <= xb_next;
            yb_reg        <= yb_next;
            subw_reg      <= subw_next;
            subh_reg      <= subh_next;
            n_reg         <= n_next;
            status_reg    <= status_next;
            remw_nz_reg   <= remw_nz_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            tx_reg        <= tx_next;
            cit_reg       <= cit_next;
            band_reg      <= band_next;
            valid_reg     <= valid_next;
            bend_reg      <= bend_next;
            k_reg         <= k_next;
            div_go_reg    <= div_go_next;
            sq_go_reg     <= sq_go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        pix_reg      <= pix_next;
        addr_reg     <= addr_next;
        s1_reg       <= s1_next;
        s2_reg       <= s2_next;
        prod_reg     <= mul_a * mul_b;
        acc_reg      <= acc_next;
        var_reg      <= var_next;
        mean_reg     <= mean_next;
        root_reg     <= root_next;
        sd_reg       <= sd_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/core/bms_acc_ram.sv
// ============================================================================
// bms_acc_ram
// Per-tile accumulator memory: sum in the low bits, sum of squares above.
// One write and one registered read each cycle.
// ============================================================================
`default_nettype none

module bms_acc_ram (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [bms_pkg::ADDR_W-1:0]  waddr,
    input  wire logic [bms_pkg::ENTRY_W-1:0] wdata,
    input  wire logic [bms_pkg::ADDR_W-1:0]  raddr,
    output logic      [bms_pkg::ENTRY_W-1:0] rdata
);

    logic [bms_pkg::ENTRY_W-1:0] mem [bms_pkg::MAX_X_BLOCKS];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/bms_div.sv
// ============================================================================
// bms_div
// Restoring divider, one quotient bit per cycle. Gives a 16-bit quotient
// that saturates at all ones, and the remainder when it does not saturate.
// ============================================================================
`default_nettype none

module bms_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [bms_pkg::DVD_W-1:0] dividend,
    input  wire logic [bms_pkg::N_W-1:0]   divisor,
    output logic                           done,
    output logic      [bms_pkg::Q_W-1:0]   quot,
    output logic      [bms_pkg::N_W-1:0]   rem
);

    logic [bms_pkg::DVD_W-1:0] rem_reg;
    logic [bms_pkg::DSH_W-1:0] dsh_reg;
    logic [bms_pkg::Q_W-1:0]   q_reg;
    logic                      sat_reg;
    logic [4:0]                cnt_reg;
    logic                      done_reg;
    logic                      fits;

    // The trial subtrahend is the divisor shifted to the current bit.
    assign fits = rem_reg >= {1'b0, dsh_reg};

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= 5'd16;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cnt_reg == 5'd1;
            if (cnt_reg != 5'd0)
            begin
                cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsh_reg <= {divisor, 15'b0};
            sat_reg <= dividend >= {divisor, 16'b0};
            q_reg   <= '0;
        end
        else if (cnt_reg != 5'd0)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - {1'b0, dsh_reg};
            end
            q_reg   <= {q_reg[bms_pkg::Q_W-2:0], fits};
            dsh_reg <= {1'b0, dsh_reg[bms_pkg::DSH_W-1:1]};
        end
    end

    assign done = done_reg;
    assign quot = sat_reg ? '1 : q_reg;
    assign rem  = rem_reg[bms_pkg::N_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/bms_isqrt.sv
// ============================================================================
// bms_isqrt
// Integer square root, one root bit per cycle, by the digit-by-digit method.
// ============================================================================
`default_nettype none

module bms_isqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [bms_pkg::RAD_W-1:0]  radicand,
    output logic                            done,
    output logic      [bms_pkg::ROOT_W-1:0] root
);

    localparam int REM_W = bms_pkg::ROOT_W + 4;

    logic [bms_pkg::RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [bms_pkg::ROOT_W-1:0] root_reg;
    logic [5:0]                 cnt_reg;
    logic                       done_reg;
    logic [REM_W-1:0]           rem_sh;
    logic [REM_W-1:0]           trial;
    logic                       fits;

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[bms_pkg::RAD_W-1 -: 2]};
    assign trial  = {2'b0, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= 6'(bms_pkg::ROOT_W);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cnt_reg == 6'd1;
            if (cnt_reg != 6'd0)
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    // Remainder and root.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != 6'd0)
        begin
            rem_reg  <= fits ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[bms_pkg::ROOT_W-2:0], fits};
            rad_reg  <= {rad_reg[bms_pkg::RAD_W-3:0], 2'b0};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire
